>>> design/r2sa_pkg.sv
package r2sa_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 17;
   localparam int LIMB_W   = 17;
   localparam int RESID_W  = 49;
   localparam int SUM_W    = 33;
   localparam int SQSUM_W  = 47;
   localparam int WIDE_W   = 64;
   localparam int QUO_W    = 34;
   localparam int FRAC_W   = 17;
   localparam int DIV_STEPS = WIDE_W + FRAC_W;
   localparam int STEP_W   = 7;
   localparam int MUL_STEPS = 10;

   localparam logic [FRAC_W-1:0] SAT_WHOLE = 17'd40000;
   localparam logic signed [35:0] ONE_Q16 = 36'sd65536;
   localparam logic signed [35:0] R2_MIN  = -36'sd2147483648;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_VAR = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_DIFF,
      ST_SQ_ACT,
      ST_FIN,
      ST_MUL,
      ST_CHECK,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              done;
      logic              big;
      logic [QUO_W-1:0]  quo;
   } div_result_type;

endpackage

>>> design/r2sa_mac.sv
module r2sa_mac import r2sa_pkg::*; (
   input  logic [LIMB_W-1:0] op_a,
   input  logic [LIMB_W-1:0] op_b,
   input  logic [1:0]        limb_shift,
   input  logic              subtract,
   input  logic [WIDE_W-1:0] acc,
   output logic [WIDE_W-1:0] sum
);

   logic [2*LIMB_W-1:0] product;
   logic [WIDE_W-1:0]   addend;

   assign product = op_a * op_b;

   always_comb begin
      case (limb_shift)
         2'd0: addend = WIDE_W'(product);
         2'd1: addend = WIDE_W'(product) << LIMB_W;
         2'd2: addend = WIDE_W'(product) << (2 * LIMB_W);
         2'd3: addend = WIDE_W'(product) << (3 * LIMB_W);
         default: addend = WIDE_W'(product);
      endcase
   end

   assign sum = subtract ? acc - addend : acc + addend;

endmodule

>>> design/r2sa_divider.sv
module r2sa_divider import r2sa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDE_W-1:0]    dividend,
   input  logic [WIDE_W-1:0]    divisor,
   output div_result_type       result
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   iter_ff, iter_in;
   logic [WIDE_W-1:0]   rem_ff, rem_in;
   logic [WIDE_W-1:0]   dvd_ff, dvd_in;
   logic [WIDE_W-1:0]   dsr_ff, dsr_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic                big_ff, big_in;
   logic [WIDE_W-1:0]   rem_shift;
   logic                fits;

   assign rem_shift = {rem_ff[WIDE_W-2:0], dvd_ff[WIDE_W-1]};
   assign fits = rem_shift >= dsr_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      big_in  = big_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         quo_in  = '0;
         big_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? rem_shift - dsr_ff : rem_shift;
         dvd_in = {dvd_ff[WIDE_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fits};
         big_in = big_ff | quo_ff[QUO_W-1];
         iter_in = iter_ff + 1'b1;
         if (iter_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      big_ff <= big_in;
   end

   assign result = '{done: done_ff, big: big_ff, quo: quo_ff};

endmodule

>>> design/r2_score_accumulator.sv
// a pair is accepted, then its squared difference and its squared actual are added
// all pairs share one 17x17 multiply-add; no new pair is taken until the last is through
// a last pair adds 10 multiply-add steps, one check and 81 divider iterations
// (all skipped on overflow, divider on zero variance), then waits for the result port
// reset clears all sums, the pair count, the overflow flag and the result beat
module r2_score_accumulator import r2sa_pkg::*; #(
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // actual [15:0], predicted [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // r2 [31:0]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam logic [SAMPLE_W-1:0] SampleMask = SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);
   localparam logic [SAMPLE_W-1:0] SampleSign = SAMPLE_W'(33'd1 << (SAMPLE_BITS - 1));
   localparam logic [COUNT_W-1:0]  CountFull  = COUNT_W'(MAX_SAMPLES);

   state_type                 state_ff, state_in;
   logic [LIMB_W-1:0]         mag_d_ff, mag_d_in;
   logic signed [LIMB_W-1:0]  act_ff, act_in;
   logic                      last_ff, last_in;
   logic [RESID_W-1:0]        resid_ff, resid_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQSUM_W-1:0]        sqsum_ff, sqsum_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic [3:0]                step_ff, step_in;
   logic [WIDE_W-1:0]         num_ff, num_in;
   logic [WIDE_W-1:0]         den_ff, den_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_r2_ff, rsp_r2_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   logic [SAMPLE_W-1:0]       act_raw, pred_raw;
   logic signed [LIMB_W-1:0]  act_val, pred_val;
   logic signed [LIMB_W:0]    diff;
   logic [LIMB_W-1:0]         act_mag;
   logic [31:0]               sum_mag;
   logic [3*LIMB_W-1:0]       resid_pad, sqsum_pad;
   logic [2*LIMB_W-1:0]       sum_pad;
   logic [LIMB_W-1:0]         mac_a, mac_b;
   logic [1:0]                mac_shift;
   logic                      mac_sub;
   logic [WIDE_W-1:0]         mac_acc, mac_sum;
   logic                      div_start;
   div_result_type            div_res;
   logic [FRAC_W-1:0]         whole;
   logic [QUO_W-1:0]          q_round;
   logic signed [35:0]        r2_wide;
   logic [31:0]               r2_val;
   logic                      accepted;

   assign act_raw  = req_tdata[15:0] & SampleMask;
   assign pred_raw = req_tdata[31:16] & SampleMask;
   assign act_val  = $signed({1'b0, act_raw ^ SampleSign}) - $signed({1'b0, SampleSign});
   assign pred_val = $signed({1'b0, pred_raw ^ SampleSign}) - $signed({1'b0, SampleSign});
   assign diff     = {act_val[LIMB_W-1], act_val} - {pred_val[LIMB_W-1], pred_val};

   assign act_mag   = act_ff[LIMB_W-1] ? LIMB_W'(-act_ff) : act_ff;
   assign sum_mag   = sum_ff[SUM_W-1] ? 32'(-sum_ff) : 32'(sum_ff);
   assign resid_pad = (3*LIMB_W)'(resid_ff);
   assign sqsum_pad = (3*LIMB_W)'(sqsum_ff);
   assign sum_pad   = (2*LIMB_W)'(sum_mag);

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accepted   = req_tvalid && req_tready;

   // operand selection for the shared multiply-add
   always_comb begin
      mac_a     = '0;
      mac_b     = '0;
      mac_shift = 2'd0;
      mac_sub   = 1'b0;
      mac_acc   = den_ff;
      case (state_ff)
         ST_SQ_DIFF: begin
            mac_a   = mag_d_ff;
            mac_b   = mag_d_ff;
            mac_acc = WIDE_W'(resid_ff);
         end
         ST_SQ_ACT: begin
            mac_a   = act_mag;
            mac_b   = act_mag;
            mac_acc = WIDE_W'(sqsum_ff);
         end
         ST_MUL: begin
            case (step_ff)
               4'd0: begin
                  mac_a = count_ff; mac_b = resid_pad[0 +: LIMB_W];
                  mac_shift = 2'd0; mac_acc = num_ff;
               end
               4'd1: begin
                  mac_a = count_ff; mac_b = resid_pad[LIMB_W +: LIMB_W];
                  mac_shift = 2'd1; mac_acc = num_ff;
               end
               4'd2: begin
                  mac_a = count_ff; mac_b = resid_pad[2*LIMB_W +: LIMB_W];
                  mac_shift = 2'd2; mac_acc = num_ff;
               end
               4'd3: begin
                  mac_a = count_ff; mac_b = sqsum_pad[0 +: LIMB_W];
                  mac_shift = 2'd0;
               end
               4'd4: begin
                  mac_a = count_ff; mac_b = sqsum_pad[LIMB_W +: LIMB_W];
                  mac_shift = 2'd1;
               end
               4'd5: begin
                  mac_a = count_ff; mac_b = sqsum_pad[2*LIMB_W +: LIMB_W];
                  mac_shift = 2'd2;
               end
               4'd6: begin
                  mac_a = sum_pad[0 +: LIMB_W]; mac_b = sum_pad[0 +: LIMB_W];
                  mac_shift = 2'd0; mac_sub = 1'b1;
               end
               4'd7: begin
                  mac_a = sum_pad[0 +: LIMB_W]; mac_b = sum_pad[LIMB_W +: LIMB_W];
                  mac_shift = 2'd1; mac_sub = 1'b1;
               end
               4'd8: begin
                  mac_a = sum_pad[LIMB_W +: LIMB_W]; mac_b = sum_pad[0 +: LIMB_W];
                  mac_shift = 2'd1; mac_sub = 1'b1;
               end
               4'd9: begin
                  mac_a = sum_pad[LIMB_W +: LIMB_W]; mac_b = sum_pad[LIMB_W +: LIMB_W];
                  mac_shift = 2'd2; mac_sub = 1'b1;
               end
               default: begin
                  mac_a = '0;
               end
            endcase
         end
         default: begin
            mac_a = '0;
         end
      endcase
   end

   r2sa_mac u_mac (
      .op_a       (mac_a),
      .op_b       (mac_b),
      .limb_shift (mac_shift),
      .subtract   (mac_sub),
      .acc        (mac_acc),
      .sum        (mac_sum)
   );

   r2sa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (den_ff),
      .result   (div_res)
   );

   // rounding and saturation of the quotient
   assign whole   = div_res.quo[QUO_W-1:FRAC_W];
   assign q_round = QUO_W'(({1'b0, div_res.quo} + (QUO_W+1)'(1)) >> 1);
   assign r2_wide = ONE_Q16 - $signed({2'b00, q_round});
   assign r2_val  = (div_res.big || whole > SAT_WHOLE || r2_wide < R2_MIN) ?
                    32'(R2_MIN) : 32'(r2_wide);

   always_comb begin
      state_in      = state_ff;
      mag_d_in      = mag_d_ff;
      act_in        = act_ff;
      last_in       = last_ff;
      resid_in      = resid_ff;
      sum_in        = sum_ff;
      sqsum_in      = sqsum_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      step_in       = step_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_r2_in     = rsp_r2_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               mag_d_in = diff[LIMB_W] ? LIMB_W'(-diff) : LIMB_W'(diff);
               act_in   = act_val;
               last_in  = req_tlast;
               if (count_ff < CountFull) begin
                  state_in = ST_SQ_DIFF;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = req_tlast ? ST_FIN : ST_IDLE;
               end
            end
         end
         ST_SQ_DIFF: begin
            resid_in = RESID_W'(mac_sum);
            state_in = ST_SQ_ACT;
         end
         ST_SQ_ACT: begin
            sqsum_in = SQSUM_W'(mac_sum);
            sum_in   = sum_ff + SUM_W'(act_ff);
            count_in = count_ff + 1'b1;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            num_in  = '0;
            den_in  = '0;
            step_in = '0;
            state_in = ovf_ff ? ST_OUT : ST_MUL;
         end
         ST_MUL: begin
            if (step_ff < 4'd3) begin
               num_in = mac_sum;
            end else begin
               den_in = mac_sum;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 4'(MUL_STEPS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_res.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (ovf_ff) begin
                  rsp_status_in = STATUS_OVERFLOW;
                  rsp_r2_in     = '0;
               end else if (den_ff == '0) begin
                  rsp_status_in = STATUS_ZERO_VAR;
                  rsp_r2_in     = '0;
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_r2_in     = r2_val;
               end
               resid_in = '0;
               sum_in   = '0;
               sqsum_in = '0;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resid_ff     <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resid_ff     <= resid_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_d_ff      <= mag_d_in;
      act_ff        <= act_in;
      last_ff       <= last_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rsp_r2_ff     <= rsp_r2_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_r2_ff;
   assign rsp_tuser  = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside the output step");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("error status with nonzero r2");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OK |-> $signed(rsp_tdata) <= 32'sd65536)
      else $error("r2 above one");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountFull)
      else $error("pair count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      div_start |-> den_ff != '0)
      else $error("divider started with zero divisor");

endmodule

>>> tb/tb_r2_score_accumulator.sv
`timescale 1ns / 1ps

module tb_r2_score_accumulator import r2sa_pkg::*;;

   localparam int MAX_PAIRS   = 65536;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [31:0] r2;
      logic [1:0]  status;
   } score_type;

   class r2_scoreboard;
      logic [63:0]  residual_acc;
      longint       actual_acc;
      logic [63:0]  square_acc;
      int unsigned  pair_count;
      bit           overflow_seen;
      score_type    expected_scores[$];
      int           errors;

      function new();
         clear_sums();
         errors = 0;
      endfunction

      function void clear_sums();
         residual_acc  = '0;
         actual_acc    = 0;
         square_acc    = '0;
         pair_count    = 0;
         overflow_seen = 1'b0;
      endfunction

      // 1 - num/den in q16.16, quotient rounded half up, saturated low
      function logic [31:0] r2_quotient(logic [63:0] num, logic [63:0] den);
         logic [63:0] whole;
         logic [63:0] rem;
         logic [63:0] frac;
         logic [63:0] q;
         logic        hi;
         longint      score;
         whole = num / den;
         rem   = num % den;
         frac  = '0;
         if (whole > 64'd40000) begin
            return 32'h8000_0000;
         end
         for (int i = 0; i < FRAC_W; i++) begin
            hi   = rem[63];
            rem  = rem << 1;
            frac = frac << 1;
            if (hi || rem >= den) begin
               rem     = rem - den;
               frac[0] = 1'b1;
            end
         end
         q     = (((whole << FRAC_W) | frac) + 64'd1) >> 1;
         score = 65536 - longint'(q);
         if (score < -64'sd2147483648) begin
            score = -64'sd2147483648;
         end
         return score[31:0];
      endfunction

      function void note_pair(logic signed [15:0] act, logic signed [15:0] pred,
                              logic last);
         longint      y;
         longint      yh;
         longint      diff;
         logic [63:0] n;
         logic [63:0] sabs;
         logic [63:0] den;
         score_type   score;
         y  = act;
         yh = pred;
         if (pair_count < MAX_PAIRS) begin
            diff         = y - yh;
            residual_acc = residual_acc + 64'(diff * diff);
            actual_acc   = actual_acc + y;
            square_acc   = square_acc + 64'(y * y);
            pair_count++;
         end else begin
            overflow_seen = 1'b1;
         end
         if (!last) begin
            return;
         end
         score.r2     = '0;
         score.status = STATUS_OK;
         if (overflow_seen) begin
            score.status = STATUS_OVERFLOW;
         end else begin
            n    = 64'(pair_count);
            sabs = (actual_acc < 0) ? 64'(-actual_acc) : 64'(actual_acc);
            den  = n * square_acc - sabs * sabs;
            if (den == 0) begin
               score.status = STATUS_ZERO_VAR;
            end else begin
               score.r2 = r2_quotient(n * residual_acc, den);
            end
         end
         expected_scores.push_back(score);
         clear_sums();
      endfunction

      function void check_result(logic [31:0] r2, logic [1:0] status);
         score_type want;
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected result beat r2=%0d status=%0d",
                     $time, $signed(r2), status);
            errors++;
            return;
         end
         want = expected_scores.pop_front();
         if (r2 !== want.r2) begin
            $display("%0t: r2 mismatch expected=%0d actual=%0d",
                     $time, $signed(want.r2), $signed(r2));
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, want.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_scores.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // actual [15:0], predicted [31:16]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // r2 [31:0]
   logic [1:0]  rsp_tuser;          // status [1:0]

   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          stall_cycles = 0;
   r2_scoreboard sb = new();

   r2_score_accumulator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_pair(req_tdata[15:0], req_tdata[31:16], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser);
         end
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb_r2_score_accumulator: errors");
      $finish;
   end

   task automatic send_pair(input logic [15:0] act, input logic [15:0] pred,
                            input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pred, act};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] edge_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'hFFFF;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   task automatic send_random_sets(input int pair_total);
      int          sent;
      int          len;
      int          style;
      int          pick;
      logic [15:0] act;
      logic [15:0] pred;
      logic [15:0] base;
      sent = 0;
      while (sent < pair_total) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            len = 1;
         end else if (pick < 80) begin
            len = $urandom_range(2, 8);
         end else begin
            len = $urandom_range(9, 40);
         end
         style = $urandom_range(0, 4);
         base  = 16'($urandom);
         for (int i = 0; i < len; i++) begin
            case (style)
               0: begin
                  act  = 16'($urandom);
                  pred = 16'($urandom);
               end
               1: begin
                  act  = 16'($urandom);
                  pred = act + 16'($urandom_range(0, 64)) - 16'd32;
               end
               2: begin
                  act  = base;
                  pred = 16'($urandom);
               end
               3: begin
                  act  = edge_value();
                  pred = edge_value();
               end
               default: begin
                  act  = 16'($urandom_range(0, 32)) - 16'd16;
                  pred = 16'($urandom_range(0, 32)) - 16'd16;
               end
            endcase
            send_pair(act, pred, i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single pair, always zero variance
      send_pair(16'd100, 16'd50, 1'b1);
      // opposite extremes
      send_pair(16'h7FFF, 16'h8000, 1'b0);
      send_pair(16'h8000, 16'h7FFF, 1'b1);
      // perfect prediction
      send_pair(16'd1000, 16'd1000, 1'b0);
      send_pair(-16'sd2000, -16'sd2000, 1'b0);
      send_pair(16'd3, 16'd3, 1'b1);
      // constant actuals with prediction error
      send_pair(16'd5, 16'd0, 1'b0);
      send_pair(16'd5, 16'd7, 1'b0);
      send_pair(16'd5, -16'sd3, 1'b1);
      // tiny variance, huge residual: saturates low
      send_pair(16'd0, 16'h8000, 1'b0);
      send_pair(16'd1, 16'h7FFF, 1'b1);
      // negative actual sum
      send_pair(16'h8000, -16'sd32760, 1'b0);
      send_pair(-16'sd32767, 16'h8000, 1'b0);
      send_pair(16'hFFFF, 16'd0, 1'b1);
      // zero predictions
      send_pair(16'd300, 16'd0, 1'b0);
      send_pair(-16'sd200, 16'd0, 1'b1);

      send_random_sets(50);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         send_random_sets(250);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_r2_score_accumulator: clean");
      end else begin
         $display("tb_r2_score_accumulator: errors");
      end
      $finish;
   end

endmodule
